// File: rtl/core/accumulator_cpu_step_unit_defines.svh
// assertion helpers, sampled on clk with rst_n low as the disable
`ifndef ACCUMULATOR_CPU_STEP_UNIT_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define ACS_ASSERT_SAME(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("acs check failed");

// next-cycle implication
`define ACS_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("acs check failed");

`endif

// File: rtl/core/acs_pkg.sv
package acs_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WRITE   = 2'd0;
  localparam cmd_t CMD_READ    = 2'd1;
  localparam cmd_t CMD_EXEC    = 2'd2;
  localparam cmd_t CMD_RESTART = 2'd3;

  typedef logic [3:0] opc_t;
  localparam opc_t OPC_NOP     = 4'd0;
  localparam opc_t OPC_LOAD_A  = 4'd1;
  localparam opc_t OPC_STORE_A = 4'd2;
  localparam opc_t OPC_JUMP    = 4'd3;
  localparam opc_t OPC_JUMP_NZ = 4'd4;
  localparam opc_t OPC_RETURN  = 4'd5;
  localparam opc_t OPC_ARIT    = 4'd6;
  localparam opc_t OPC_HALT    = 4'd15;

  typedef logic [2:0] alu_op_t;
  localparam alu_op_t ALU_CLR  = 3'd0;
  localparam alu_op_t ALU_ONES = 3'd1;
  localparam alu_op_t ALU_NOT  = 3'd2;
  localparam alu_op_t ALU_AND  = 3'd3;
  localparam alu_op_t ALU_OR   = 3'd4;
  localparam alu_op_t ALU_XOR  = 3'd5;
  localparam alu_op_t ALU_ADD  = 3'd6;
  localparam alu_op_t ALU_SUB  = 3'd7;

  typedef logic [2:0] reg_code_t;
  localparam reg_code_t REG_A   = 3'd0;
  localparam reg_code_t REG_B   = 3'd1;
  localparam reg_code_t REG_C   = 3'd2;
  localparam reg_code_t REG_D   = 3'd3;
  localparam reg_code_t REG_R   = 3'd6;
  localparam reg_code_t REG_PSW = 3'd7;

  typedef logic [1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_ADDR_MEM_SIZE = 2'd0;

  // step addresses of the control program
  typedef logic [4:0] upc_t;
  localparam upc_t STEP_IDLE     = 5'd0;
  localparam upc_t STEP_WRITE    = 5'd1;
  localparam upc_t STEP_READ     = 5'd2;
  localparam upc_t STEP_READ_CAP = 5'd3;
  localparam upc_t STEP_EXEC     = 5'd4;
  localparam upc_t STEP_DECODE   = 5'd5;
  localparam upc_t STEP_LOAD     = 5'd6;
  localparam upc_t STEP_LOAD_CAP = 5'd7;
  localparam upc_t STEP_STORE    = 5'd8;
  localparam upc_t STEP_JUMP     = 5'd9;
  localparam upc_t STEP_JUMP_NZ  = 5'd10;
  localparam upc_t STEP_RETURN   = 5'd11;
  localparam upc_t STEP_ARIT     = 5'd12;
  localparam upc_t STEP_HALT     = 5'd13;
  localparam upc_t STEP_RESTART  = 5'd14;
  localparam upc_t STEP_PC_UPD   = 5'd15;
  localparam upc_t STEP_EMIT     = 5'd16;
  localparam upc_t STEP_LAST     = STEP_EMIT;
  localparam int   UROM_DEPTH    = 17;

  typedef enum logic [2:0] {
    MEM_NONE    = 3'd0,
    MEM_RD_ADDR = 3'd1,
    MEM_RD_PC   = 3'd2,
    MEM_RD_ARG  = 3'd3,
    MEM_WR_DATA = 3'd4,
    MEM_WR_ACC  = 3'd5
  } mem_op_t;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_LATCH   = 4'd1,
    ACT_RD_DATA = 4'd2,
    ACT_FETCH   = 4'd3,
    ACT_LOAD_A  = 4'd4,
    ACT_CALL    = 4'd5,
    ACT_CALL_NZ = 4'd6,
    ACT_RET     = 4'd7,
    ACT_ARIT    = 4'd8,
    ACT_HALT    = 4'd9,
    ACT_RESTART = 4'd10,
    ACT_PC_UPD  = 4'd11
  } act_t;

  typedef enum logic [2:0] {
    SEQ_NEXT   = 3'd0,
    SEQ_GOTO   = 3'd1,
    SEQ_CMD    = 3'd2,
    SEQ_OP     = 3'd3,
    SEQ_HALTED = 3'd4,
    SEQ_EMIT   = 3'd5
  } seq_t;

  typedef struct packed {
    mem_op_t mem;
    act_t    act;
    seq_t    seq;
    upc_t    target;
  } ucw_t;

  typedef struct packed {
    logic        en;
    logic        we;
    logic [11:0] addr;
    logic [15:0] wdata;
  } ram_req_t;

  localparam ucw_t UROM [UROM_DEPTH] = '{
    '{MEM_NONE,    ACT_LATCH,   SEQ_CMD,    STEP_IDLE},
    '{MEM_WR_DATA, ACT_NONE,    SEQ_GOTO,   STEP_EMIT},
    '{MEM_RD_ADDR, ACT_NONE,    SEQ_NEXT,   STEP_IDLE},
    '{MEM_NONE,    ACT_RD_DATA, SEQ_GOTO,   STEP_EMIT},
    '{MEM_RD_PC,   ACT_NONE,    SEQ_HALTED, STEP_EMIT},
    '{MEM_NONE,    ACT_FETCH,   SEQ_OP,     STEP_IDLE},
    '{MEM_RD_ARG,  ACT_NONE,    SEQ_NEXT,   STEP_IDLE},
    '{MEM_NONE,    ACT_LOAD_A,  SEQ_GOTO,   STEP_PC_UPD},
    '{MEM_WR_ACC,  ACT_NONE,    SEQ_GOTO,   STEP_PC_UPD},
    '{MEM_NONE,    ACT_CALL,    SEQ_GOTO,   STEP_PC_UPD},
    '{MEM_NONE,    ACT_CALL_NZ, SEQ_GOTO,   STEP_PC_UPD},
    '{MEM_NONE,    ACT_RET,     SEQ_GOTO,   STEP_PC_UPD},
    '{MEM_NONE,    ACT_ARIT,    SEQ_GOTO,   STEP_PC_UPD},
    '{MEM_NONE,    ACT_HALT,    SEQ_GOTO,   STEP_EMIT},
    '{MEM_NONE,    ACT_RESTART, SEQ_GOTO,   STEP_EMIT},
    '{MEM_NONE,    ACT_PC_UPD,  SEQ_NEXT,   STEP_IDLE},
    '{MEM_NONE,    ACT_NONE,    SEQ_EMIT,   STEP_IDLE}
  };

  function automatic upc_t cmd_entry(cmd_t c);
    upc_t s;
    case (c)
      CMD_WRITE: s = STEP_WRITE;
      CMD_READ:  s = STEP_READ;
      CMD_EXEC:  s = STEP_EXEC;
      default:   s = STEP_RESTART;
    endcase
    return s;
  endfunction

  function automatic upc_t op_entry(opc_t o);
    upc_t s;
    case (o)
      OPC_LOAD_A:  s = STEP_LOAD;
      OPC_STORE_A: s = STEP_STORE;
      OPC_JUMP:    s = STEP_JUMP;
      OPC_JUMP_NZ: s = STEP_JUMP_NZ;
      OPC_RETURN:  s = STEP_RETURN;
      OPC_ARIT:    s = STEP_ARIT;
      OPC_HALT:    s = STEP_HALT;
      default:     s = STEP_PC_UPD;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/acs_channels.sv
interface acs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] address;
  logic [15:0] write_data;

  modport source (output valid, output command, output address, output write_data,
                  input ready);
  modport sink (input valid, input command, input address, input write_data,
                output ready);
endinterface

interface acs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [11:0] pc_value;
  logic        halted;
  logic [15:0] acc_value;

  modport source (output valid, output read_data, output pc_value, output halted,
                  output acc_value, input ready);
  modport sink (input valid, input read_data, input pc_value, input halted,
                input acc_value, output ready);
endinterface

// File: rtl/core/acs_ram.sv
module acs_ram #(
  parameter int WORDS = 4096
) (
  input  logic              clk,
  input  acs_pkg::ram_req_t req,
  output logic [15:0]       q
);
  import acs_pkg::*;

  localparam int AW = $clog2(WORDS);

  logic [15:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr[AW-1:0]] <= req.wdata;
      end else begin
        q <= mem[req.addr[AW-1:0]];
      end
    end
  end

endmodule

// File: rtl/core/acs_alu.sv
module acs_alu (
  input  acs_pkg::alu_op_t op,
  input  logic [15:0]      x,
  input  logic [15:0]      y,
  output logic [15:0]      res
);
  import acs_pkg::*;

  always_comb begin
    case (op)
      ALU_CLR:  res = '0;
      ALU_ONES: res = '1;
      ALU_NOT:  res = ~x;
      ALU_AND:  res = x & y;
      ALU_OR:   res = x | y;
      ALU_XOR:  res = x ^ y;
      ALU_ADD:  res = x + y;
      ALU_SUB:  res = x - y;
      default:  res = '0;
    endcase
  end

endmodule

// File: rtl/core/accumulator_cpu_step_unit.sv
// channel   dir  fields                                     handshake
// in_chan   in   command, address, write_data               valid/ready
// out_chan  out  read_data, pc_value, halted, acc_value     valid/ready
// cfg_*     in   mem_size at byte address 0 (13 bits)       apb, pready tied high
//
// one request at a time, run by a microprogram over a single-port word memory
// fetch reads in the exec step and captures in decode; a load reads in load
// and captures in load_cap; a store writes in the store step of the sequencer
// the result sits in an output register; a stalled out_chan holds the sequencer
// in its emit step; rst_n is synchronous and clears control and machine registers
`include "accumulator_cpu_step_unit_defines.svh"

module accumulator_cpu_step_unit #(
  parameter int MEM_WORDS = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  acs_in_if.sink                in_chan,
  acs_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  acs_pkg::cfg_addr_t    cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import acs_pkg::*;

  localparam logic [12:0] WORDS13 = 13'(MEM_WORDS);

  upc_t        upc_r, upc_nxt;
  ucw_t        ucw;
  logic        accept, emit, in_ready;

  logic [11:0] addr_r;
  logic [15:0] wdata_r;
  logic [15:0] rd_r;
  logic [15:0] ir_r;
  logic [15:0] npc_r;

  logic [11:0] pc_r;
  logic [15:0] a_r, b_r, c_r, d_r, r_r, psw_r;
  logic        halt_r;

  logic [12:0] mem_size_r, lim_r;
  logic [12:0] cfg_v, cfg_lim;
  logic        cfg_wr;

  logic        out_valid_r;
  logic [15:0] out_rd_r, out_acc_r;
  logic [11:0] out_pc_r;
  logic        out_halt_r;

  ram_req_t    ram_req;
  logic [15:0] mem_q;
  logic        addr_ok, arg_ok;
  logic [11:0] arg;
  logic [15:0] pc_plus1;
  logic [15:0] op_x, op_y, alu_res;

  // configuration
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == CFG_ADDR_MEM_SIZE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_MEM_SIZE) ? {19'd0, mem_size_r} : '0;
  assign cfg_v      = cfg_pwdata[12:0];

  always_comb begin
    if (cfg_v == '0) begin
      cfg_lim = 13'd1;
    end else if (cfg_v > WORDS13) begin
      cfg_lim = WORDS13;
    end else begin
      cfg_lim = cfg_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= 13'd4096;
      lim_r      <= WORDS13;
    end else if (cfg_wr) begin
      mem_size_r <= cfg_v;
      lim_r      <= cfg_lim;
    end
  end

  // sequencer
  always_comb begin
    ucw      = (upc_r < 5'(UROM_DEPTH)) ? UROM[upc_r] : UROM[STEP_IDLE];
    in_ready = 1'b0;
    emit     = 1'b0;
    case (ucw.seq)
      SEQ_NEXT: upc_nxt = upc_r + 5'd1;
      SEQ_GOTO: upc_nxt = ucw.target;
      SEQ_CMD: begin
        in_ready = 1'b1;
        upc_nxt  = in_chan.valid ? cmd_entry(in_chan.command) : upc_r;
      end
      SEQ_OP:     upc_nxt = op_entry(mem_q[15:12]);
      SEQ_HALTED: upc_nxt = halt_r ? ucw.target : upc_r + 5'd1;
      SEQ_EMIT: begin
        emit    = !out_valid_r || out_chan.ready;
        upc_nxt = emit ? ucw.target : upc_r;
      end
      default: upc_nxt = STEP_IDLE;
    endcase
  end

  assign in_chan.ready = in_ready;
  assign accept        = in_ready && in_chan.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // memory requests
  assign arg      = ir_r[11:0];
  assign addr_ok  = {1'b0, addr_r} < WORDS13;
  assign arg_ok   = {1'b0, arg} < WORDS13;
  assign pc_plus1 = {4'd0, pc_r} + 16'd1;

  always_comb begin
    ram_req = '{en: 1'b0, we: 1'b0, addr: addr_r, wdata: wdata_r};
    case (ucw.mem)
      MEM_RD_ADDR: ram_req.en = addr_ok;
      MEM_RD_PC: begin
        ram_req.en   = 1'b1;
        ram_req.addr = pc_r;
      end
      MEM_RD_ARG: begin
        ram_req.en   = arg_ok;
        ram_req.addr = arg;
      end
      MEM_WR_DATA: begin
        ram_req.en = addr_ok;
        ram_req.we = 1'b1;
      end
      MEM_WR_ACC: begin
        ram_req.en    = arg_ok;
        ram_req.we    = 1'b1;
        ram_req.addr  = arg;
        ram_req.wdata = a_r;
      end
      default: ram_req.en = 1'b0;
    endcase
  end

  acs_ram #(.WORDS(MEM_WORDS)) u_ram (
    .clk (clk),
    .req (ram_req),
    .q   (mem_q)
  );

  // register file read ports
  function automatic logic [15:0] reg_get(reg_code_t code, logic [15:0] a, logic [15:0] b,
                                          logic [15:0] c, logic [15:0] d, logic [15:0] r,
                                          logic [15:0] p);
    logic [15:0] v;
    case (code)
      REG_A:   v = a;
      REG_B:   v = b;
      REG_C:   v = c;
      REG_D:   v = d;
      REG_R:   v = r;
      REG_PSW: v = p;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign op_x = reg_get(ir_r[5:3], a_r, b_r, c_r, d_r, r_r, psw_r);
  assign op_y = reg_get(ir_r[2:0], a_r, b_r, c_r, d_r, r_r, psw_r);

  acs_alu u_alu (
    .op  (ir_r[11:9]),
    .x   (op_x),
    .y   (op_y),
    .res (alu_res)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (ucw.act == ACT_LATCH && accept) begin
      addr_r  <= in_chan.address;
      wdata_r <= in_chan.write_data;
      rd_r    <= '0;
    end
    if (ucw.act == ACT_RD_DATA) begin
      rd_r <= addr_ok ? mem_q : '0;
    end
    if (ucw.act == ACT_FETCH) begin
      ir_r  <= mem_q;
      npc_r <= pc_plus1;
    end
    if (ucw.act == ACT_CALL || (ucw.act == ACT_CALL_NZ && a_r != '0)) begin
      npc_r <= {4'd0, arg};
    end
    if (ucw.act == ACT_RET) begin
      npc_r <= r_r;
    end
  end

  // machine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      a_r    <= '0;
      b_r    <= '0;
      c_r    <= '0;
      d_r    <= '0;
      r_r    <= '0;
      psw_r  <= '0;
      halt_r <= 1'b0;
    end else begin
      case (ucw.act)
        ACT_LOAD_A: a_r <= arg_ok ? mem_q : '0;
        ACT_CALL:   r_r <= pc_plus1;
        ACT_CALL_NZ: begin
          if (a_r != '0) begin
            r_r <= pc_plus1;
          end
        end
        ACT_RET: r_r <= pc_plus1;
        ACT_ARIT: begin
          case (ir_r[8:6])
            REG_A:   a_r   <= alu_res;
            REG_B:   b_r   <= alu_res;
            REG_C:   c_r   <= alu_res;
            REG_D:   d_r   <= alu_res;
            REG_R:   r_r   <= alu_res;
            REG_PSW: psw_r <= alu_res;
            default: ;
          endcase
        end
        ACT_HALT: halt_r <= 1'b1;
        ACT_RESTART: begin
          pc_r   <= '0;
          halt_r <= 1'b0;
        end
        ACT_PC_UPD: pc_r <= (npc_r >= {3'd0, lim_r}) ? '0 : npc_r[11:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rd_r   <= rd_r;
      out_pc_r   <= pc_r;
      out_halt_r <= halt_r;
      out_acc_r  <= a_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_rd_r;
  assign out_chan.pc_value  = out_pc_r;
  assign out_chan.halted    = out_halt_r;
  assign out_chan.acc_value = out_acc_r;

  `ACS_ASSERT_NEXT(a_accept_leaves_idle, accept, upc_r != STEP_IDLE)
  `ACS_ASSERT_NEXT(a_halted_skips_exec, upc_r == STEP_EXEC && halt_r, upc_r == STEP_EMIT)
  `ACS_ASSERT_NEXT(a_emit_loads_output, emit, out_valid_r && upc_r == STEP_IDLE)
  `ACS_ASSERT_SAME(a_halt_from_step, $rose(halt_r), $past(upc_r) == STEP_HALT)
  `ACS_ASSERT_SAME(a_upc_in_program, 1'b1, upc_r <= STEP_LAST)

endmodule
